@@ src/hbs_pkg.sv @@
// Shared types, constants and helper functions of the heightmap box smoother.
// Used by the channel interfaces, the mean pipeline and the top level.
package hbs_pkg;

   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;
   localparam int COL_W = $clog2(MAX_COLS);
   localparam int ROW_W = $clog2(MAX_ROWS);
   localparam int COUNT_W = 11;
   localparam int RAW_W = 8;
   localparam int SCALE_W = 16;
   localparam int OFFSET_W = 24;
   localparam int HEIGHT_W = 25;
   localparam int SUM_W = 12;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 24;

   // Split of the 27-bit rounded magnitude for the two-step constant divide
   localparam int MAG_W = 27;
   localparam int LO_W = 14;
   localparam int HI_W = MAG_W - LO_W;
   localparam int HI_SHIFT = 17;
   localparam int LO_SHIFT = 22;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROW_COUNT     = 2'd0,
      CSR_COL_COUNT     = 2'd1,
      CSR_HEIGHT_SCALE  = 2'd2,
      CSR_HEIGHT_OFFSET = 2'd3
   } csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EMIT
   } state_type;

   // Odd factor of the neighbor count; the power of two travels as a shift
   typedef enum logic [1:0] {
      DIV_1,
      DIV_3,
      DIV_9
   } div_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [1:0]       shift;
      div_type          div;
      logic             last;
   } meta_type;

   typedef struct packed {
      meta_type         meta;
      logic [SUM_W-1:0] sum;
   } token_type;

   // Last valid index for a count register: zero reads as one, large values saturate
   function automatic logic [COL_W-1:0] clamp_last(input logic [COUNT_W-1:0] v);
      logic [COL_W-1:0] r;
      if (v[COUNT_W-1]) begin
         r = '1;
      end else if (v == '0) begin
         r = '0;
      end else begin
         r = v[COL_W-1:0] - 1'b1;
      end
      return r;
   endfunction

   function automatic logic [3:0] div_value(input div_type d);
      logic [3:0] r;
      case (d)
         DIV_3:   r = 4'd3;
         DIV_9:   r = 4'd9;
         default: r = 4'd1;
      endcase
      return r;
   endfunction

   // Half of the neighbor count, for round to nearest
   function automatic logic [4:0] round_half(input logic [1:0] shift, input div_type d);
      logic [5:0] cnt;
      cnt = {2'b00, div_value(d)} << shift;
      return cnt[5:1];
   endfunction

   // Reciprocals: floor(x * M >> HI_SHIFT) = floor(x / d) for x below 2**HI_W
   function automatic logic [17:0] recip_hi(input div_type d);
      logic [17:0] r;
      case (d)
         DIV_3:   r = 18'd43691;
         DIV_9:   r = 18'd14564;
         default: r = 18'd131072;
      endcase
      return r;
   endfunction

   // floor(x * M >> LO_SHIFT) = floor(x / d) for x below 9 * 2**LO_W
   function automatic logic [22:0] recip_lo(input div_type d);
      logic [22:0] r;
      case (d)
         DIV_3:   r = 23'd1398102;
         DIV_9:   r = 23'd466034;
         default: r = 23'd4194304;
      endcase
      return r;
   endfunction

   // d * q by shift and add
   function automatic logic [HI_W+3:0] times_div(input div_type d, input logic [HI_W-1:0] q);
      logic [HI_W+3:0] qx;
      logic [HI_W+3:0] r;
      qx = {4'b0000, q};
      case (d)
         DIV_3:   r = qx + (qx << 1);
         DIV_9:   r = qx + (qx << 3);
         default: r = qx;
      endcase
      return r;
   endfunction

endpackage

@@ src/hbs_if.sv @@
// Valid/ready channel interfaces of the heightmap box smoother.
// Depends on hbs_pkg for field widths.
interface hbs_req_if;
   logic                           valid;
   logic                           ready;
   logic [hbs_pkg::RAW_W-1:0]      raw_height;

   modport source (output valid, output raw_height, input ready);
   modport sink   (input valid, input raw_height, output ready);
endinterface

interface hbs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [hbs_pkg::ROW_W-1:0]          out_row;
   logic [hbs_pkg::COL_W-1:0]          out_col;
   logic signed [hbs_pkg::HEIGHT_W-1:0] smoothed_height;
   logic                               last_of_run;

   modport source (output valid, output out_row, output out_col,
                   output smoothed_height, output last_of_run, input ready);
   modport sink   (input valid, input out_row, input out_col,
                   input smoothed_height, input last_of_run, output ready);
endinterface

@@ src/hbs_mean_pipe.sv @@
// Scale, round-divide and offset pipeline for one smoothed cell per word.
// Depends on hbs_pkg and drives the result channel (hbs_rsp_if).
module hbs_mean_pipe (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                issue_valid,
   input  hbs_pkg::token_type                  issue_tok,
   output logic                                issue_ready,
   input  logic signed [hbs_pkg::SCALE_W-1:0]  scale,
   input  logic signed [hbs_pkg::OFFSET_W-1:0] offset,
   hbs_rsp_if.source                           rsp_bus
);

   localparam int MW = hbs_pkg::MAG_W;
   localparam int LW = hbs_pkg::LO_W;
   localparam int HW = hbs_pkg::HI_W;
   localparam int OW = hbs_pkg::HEIGHT_W;

   logic                 adv;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, out_valid_ff;
   hbs_pkg::token_type   tok1_ff;
   hbs_pkg::meta_type    meta2_ff, meta3_ff, meta4_ff, meta5_ff, meta6_ff;

   logic signed [MW+1:0] prod_full;
   logic signed [MW:0]   prod2_ff;

   logic [MW:0]          mag;
   logic [MW:0]          rounded;
   logic [MW:0]          shifted;
   logic                 neg3_ff, neg4_ff, neg5_ff, neg6_ff;
   logic [MW-1:0]        x3_ff;

   logic [HW+17:0]       qh_full;
   logic [HW-1:0]        qh4_ff, qh5_ff, qh6_ff;
   logic [HW-1:0]        xh4_ff;
   logic [LW-1:0]        xl4_ff;

   logic [HW+3:0]        rem;
   logic [LW+3:0]        low5_ff;

   logic [LW+26:0]       ql_full;
   logic [LW-1:0]        ql6_ff;

   logic [OW-1:0]        q_low;
   logic [OW-1:0]        q_signed;
   logic [OW-1:0]        height_in;

   logic [hbs_pkg::ROW_W-1:0]    out_row_ff;
   logic [hbs_pkg::COL_W-1:0]    out_col_ff;
   logic signed [OW-1:0]         out_height_ff;
   logic                         out_last_ff;

   // Stall everything while a finished word waits
   assign adv         = !out_valid_ff || rsp_bus.ready;
   assign issue_ready = adv;

   assign prod_full = scale * $signed({1'b0, tok1_ff.sum});

   always_comb begin
      mag     = prod2_ff[MW] ? (MW+1)'(-prod2_ff) : prod2_ff;
      rounded = mag + (MW+1)'(hbs_pkg::round_half(meta2_ff.shift, meta2_ff.div));
      shifted = rounded >> meta2_ff.shift;
   end

   assign qh_full = x3_ff[MW-1:LW] * hbs_pkg::recip_hi(meta3_ff.div);
   assign rem     = {4'b0000, xh4_ff} - hbs_pkg::times_div(meta4_ff.div, qh4_ff);
   assign ql_full = low5_ff * hbs_pkg::recip_lo(meta5_ff.div);

   always_comb begin
      q_low     = {qh6_ff[OW-LW-1:0], ql6_ff};
      q_signed  = neg6_ff ? OW'(-q_low) : q_low;
      height_in = q_signed + {offset[hbs_pkg::OFFSET_W-1], offset};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= issue_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         out_valid_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tok1_ff  <= issue_tok;

         meta2_ff <= tok1_ff.meta;
         prod2_ff <= prod_full[MW:0];

         meta3_ff <= meta2_ff;
         neg3_ff  <= prod2_ff[MW];
         x3_ff    <= shifted[MW-1:0];

         meta4_ff <= meta3_ff;
         neg4_ff  <= neg3_ff;
         qh4_ff   <= qh_full[HW+hbs_pkg::HI_SHIFT-1:hbs_pkg::HI_SHIFT];
         xh4_ff   <= x3_ff[MW-1:LW];
         xl4_ff   <= x3_ff[LW-1:0];

         meta5_ff <= meta4_ff;
         neg5_ff  <= neg4_ff;
         qh5_ff   <= qh4_ff;
         low5_ff  <= {rem[3:0], xl4_ff};

         meta6_ff <= meta5_ff;
         neg6_ff  <= neg5_ff;
         qh6_ff   <= qh5_ff;
         ql6_ff   <= ql_full[LW+hbs_pkg::LO_SHIFT-1:hbs_pkg::LO_SHIFT];

         out_row_ff    <= meta6_ff.row;
         out_col_ff    <= meta6_ff.col;
         out_height_ff <= $signed(height_in);
         out_last_ff   <= meta6_ff.last;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.out_row         = out_row_ff;
   assign rsp_bus.out_col         = out_col_ff;
   assign rsp_bus.smoothed_height = out_height_ff;
   assign rsp_bus.last_of_run     = out_last_ff;

endmodule

@@ src/heightmap_box_smoother.sv @@
// Heightmap box smoother: 3x3 neighborhood mean over a streamed height grid.
// Each accepted word is read from the line store, then its results enter the mean pipeline.
// An input word yields up to four results, issued in turn while the pipeline accepts them;
// the next word is taken with the final issue, or after the fetch when it yields none.
// Reset: control, positions, window and registers to defaults; line store not cleared.
module heightmap_box_smoother (
   input  logic                                  clock,
   input  logic                                  reset,
   hbs_req_if.sink                               req_bus,
   hbs_rsp_if.source                             rsp_bus,
   input  logic                                  csr_wr_en,
   input  logic [hbs_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [hbs_pkg::CSR_DATA_W-1:0]        csr_wr_data
);

   localparam int RW = hbs_pkg::RAW_W;
   localparam int CW = hbs_pkg::COL_W;
   localparam int RWW = hbs_pkg::ROW_W;

   hbs_pkg::state_type state_ff, state_in;

   logic [RWW-1:0]   row_pos_ff, row_last_ff, cur_row_ff;
   logic [CW-1:0]    col_pos_ff, col_last_ff, cur_col_ff;
   logic signed [hbs_pkg::SCALE_W-1:0]  scale_ff;
   logic signed [hbs_pkg::OFFSET_W-1:0] offset_ff;
   logic [RW-1:0]    byte_ff;

   // Line store entry: older row byte in the upper half, newer row byte in the lower
   logic [2*RW-1:0]  line_mem [hbs_pkg::MAX_COLS];
   logic [2*RW-1:0]  rd_data_ff;

   logic [RW-1:0]    win_ff [3][3];

   logic             up1_ff, up2_ff, left1_ff, left2_ff, row_end_ff, col_end_ff;
   logic             row_sel_ff, row_sel_in, col_sel_ff, col_sel_in;

   logic             geom_wr;
   logic             issue_valid, issue_ready, tok_last;
   logic             has_results;
   logic [2:0]       rmask, cmask;
   logic             r_two, r_three, c_two, c_three;
   logic [hbs_pkg::SUM_W-1:0] win_sum;
   hbs_pkg::token_type issue_tok;

   assign geom_wr = csr_wr_en && (csr_index == hbs_pkg::CSR_ROW_COUNT ||
                                  csr_index == hbs_pkg::CSR_COL_COUNT);

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_last_ff <= RWW'(255);
         col_last_ff <= CW'(255);
         scale_ff    <= 16'sd256;
         offset_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            hbs_pkg::CSR_ROW_COUNT:
               row_last_ff <= hbs_pkg::clamp_last(csr_wr_data[hbs_pkg::COUNT_W-1:0]);
            hbs_pkg::CSR_COL_COUNT:
               col_last_ff <= hbs_pkg::clamp_last(csr_wr_data[hbs_pkg::COUNT_W-1:0]);
            hbs_pkg::CSR_HEIGHT_SCALE:
               scale_ff <= $signed(csr_wr_data[hbs_pkg::SCALE_W-1:0]);
            hbs_pkg::CSR_HEIGHT_OFFSET:
               offset_ff <= $signed(csr_wr_data[hbs_pkg::OFFSET_W-1:0]);
            default: ;
         endcase
      end
   end

   // Line store: read every cycle at the current column, write back on fetch
   always_ff @(posedge clock) begin
      rd_data_ff <= line_mem[col_pos_ff];
      if (state_ff == hbs_pkg::ST_FETCH) begin
         line_mem[col_pos_ff] <= {rd_data_ff[RW-1:0], byte_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= hbs_pkg::ST_IDLE;
         row_pos_ff <= '0;
         col_pos_ff <= '0;
         row_sel_ff <= 1'b0;
         col_sel_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
               win_ff[k][m] <= '0;
            end
         end
      end else begin
         state_ff   <= state_in;
         row_sel_ff <= row_sel_in;
         col_sel_ff <= col_sel_in;
         if (geom_wr) begin
            row_pos_ff <= '0;
            col_pos_ff <= '0;
         end else if (state_ff == hbs_pkg::ST_FETCH) begin
            // Advance in raster order, wrap at the end of the frame
            if (col_pos_ff == col_last_ff) begin
               col_pos_ff <= '0;
               row_pos_ff <= (row_pos_ff == row_last_ff) ? '0 : row_pos_ff + 1'b1;
            end else begin
               col_pos_ff <= col_pos_ff + 1'b1;
            end
         end
         if (state_ff == hbs_pkg::ST_FETCH) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[k][0] <= win_ff[k][1];
               win_ff[k][1] <= win_ff[k][2];
            end
            win_ff[0][2] <= rd_data_ff[2*RW-1:RW];
            win_ff[1][2] <= rd_data_ff[RW-1:0];
            win_ff[2][2] <= byte_ff;
         end
      end
   end

   // Per-word geometry, captured while the window updates
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         byte_ff <= req_bus.raw_height;
      end
      if (state_ff == hbs_pkg::ST_FETCH) begin
         cur_row_ff <= row_pos_ff;
         cur_col_ff <= col_pos_ff;
         up1_ff     <= row_pos_ff != '0;
         up2_ff     <= row_pos_ff[RWW-1:1] != '0;
         left1_ff   <= col_pos_ff != '0;
         left2_ff   <= col_pos_ff[CW-1:1] != '0;
         row_end_ff <= row_pos_ff == row_last_ff;
         col_end_ff <= col_pos_ff == col_last_ff;
      end
   end

   assign has_results = (row_pos_ff != '0 || row_pos_ff == row_last_ff) &&
                        (col_pos_ff != '0 || col_pos_ff == col_last_ff);
   assign tok_last    = (row_sel_ff || !row_end_ff) && (col_sel_ff || !col_end_ff);

   always_comb begin
      state_in    = state_ff;
      row_sel_in  = row_sel_ff;
      col_sel_in  = col_sel_ff;
      req_bus.ready = 1'b0;
      issue_valid = 1'b0;
      unique case (state_ff)
         hbs_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               state_in = hbs_pkg::ST_FETCH;
            end
         end
         hbs_pkg::ST_FETCH: begin
            row_sel_in = row_pos_ff == '0;
            col_sel_in = col_pos_ff == '0;
            state_in   = has_results ? hbs_pkg::ST_EMIT : hbs_pkg::ST_IDLE;
         end
         hbs_pkg::ST_EMIT: begin
            issue_valid = 1'b1;
            if (issue_ready) begin
               if (tok_last) begin
                  // Take the next word in the same cycle as the final issue
                  req_bus.ready = 1'b1;
                  state_in = req_bus.valid ? hbs_pkg::ST_FETCH : hbs_pkg::ST_IDLE;
               end else if (!col_sel_ff && col_end_ff) begin
                  col_sel_in = 1'b1;
               end else begin
                  col_sel_in = !left1_ff;
                  row_sel_in = 1'b1;
               end
            end
         end
         default: state_in = hbs_pkg::ST_IDLE;
      endcase
   end

   // In-bounds masks over window rows/columns (index 0 is two back, 2 is current)
   always_comb begin
      rmask   = row_sel_ff ? {1'b0, up1_ff, 1'b1} : {up2_ff, 1'b1, 1'b1};
      cmask   = col_sel_ff ? {1'b0, left1_ff, 1'b1} : {left2_ff, 1'b1, 1'b1};
      rmask   = {rmask[0], rmask[1], rmask[2]};
      cmask   = {cmask[0], cmask[1], cmask[2]};
      r_two   = row_sel_ff ? up1_ff : !up2_ff;
      r_three = !row_sel_ff && up2_ff;
      c_two   = col_sel_ff ? left1_ff : !left2_ff;
      c_three = !col_sel_ff && left2_ff;
      win_sum = '0;
      for (int k = 0; k < 3; k++) begin
         for (int m = 0; m < 3; m++) begin
            if (rmask[k] && cmask[m]) begin
               win_sum = win_sum + hbs_pkg::SUM_W'(win_ff[k][m]);
            end
         end
      end
   end

   always_comb begin
      issue_tok.sum        = win_sum;
      issue_tok.meta.row   = row_sel_ff ? cur_row_ff : cur_row_ff - 1'b1;
      issue_tok.meta.col   = col_sel_ff ? cur_col_ff : cur_col_ff - 1'b1;
      issue_tok.meta.shift = {1'b0, r_two} + {1'b0, c_two};
      issue_tok.meta.last  = tok_last;
      if (r_three && c_three) begin
         issue_tok.meta.div = hbs_pkg::DIV_9;
      end else if (r_three || c_three) begin
         issue_tok.meta.div = hbs_pkg::DIV_3;
      end else begin
         issue_tok.meta.div = hbs_pkg::DIV_1;
      end
   end

   hbs_mean_pipe u_mean_pipe (
      .clock       (clock),
      .reset       (reset),
      .issue_valid (issue_valid),
      .issue_tok   (issue_tok),
      .issue_ready (issue_ready),
      .scale       (scale_ff),
      .offset      (offset_ff),
      .rsp_bus     (rsp_bus)
   );

endmodule

@@ src/hbs_checker.sv @@
// Port-level assertions for the heightmap box smoother, bound to its top level.
// Depends on hbs_pkg for field widths.
module hbs_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [hbs_pkg::ROW_W-1:0]          rsp_out_row,
   input logic [hbs_pkg::COL_W-1:0]          rsp_out_col,
   input logic [hbs_pkg::HEIGHT_W-1:0]       rsp_smoothed_height,
   input logic                               rsp_last_of_run
);

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_row) &&
         $stable(rsp_out_col) && $stable(rsp_smoothed_height) &&
         $stable(rsp_last_of_run)))
      else $error("result word changed while stalled");

   // An accepted word is followed by its line store fetch cycle
   a_fetch_gap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted during fetch cycle");

   // Results of one input word come out back to back
   a_run_packed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_of_run) |=> rsp_valid)
      else $error("gap inside a run of results");

   // Nothing leaves right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind heightmap_box_smoother hbs_checker u_hbs_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_bus.valid),
   .req_ready           (req_bus.ready),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_out_row         (rsp_bus.out_row),
   .rsp_out_col         (rsp_bus.out_col),
   .rsp_smoothed_height (rsp_bus.smoothed_height),
   .rsp_last_of_run     (rsp_bus.last_of_run)
);
